@@ sv/link_frame_decoder_assert.svh @@
// Assertion macros for the link frame decoder checker.
// Depends on a clock aclk and an active-low reset aresetn in the using scope.
`ifndef LINK_FRAME_DECODER_ASSERT_SVH
`define LINK_FRAME_DECODER_ASSERT_SVH

`define LFD_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("link_frame_decoder: assertion failed");

`define LFD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("link_frame_decoder: assertion failed");

`endif

@@ sv/lfd_pkg.sv @@
// Shared types, constants and result codes for the link frame decoder.
// No dependencies.
package lfd_pkg;

    localparam int HEADER_BYTES = 36;
    localparam int CNT_W        = 17;
    localparam int IDX_W        = $clog2(HEADER_BYTES);
    localparam int QUEUE_DEPTH  = 2;
    localparam int PADDR_W      = 3;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;
    localparam logic [31:0]      CRC_POLY  = 32'hEDB88320;
    localparam logic [31:0]      CRC_INIT  = 32'hFFFFFFFF;

    localparam logic [7:0] MAGIC_0 = 8'h50;
    localparam logic [7:0] MAGIC_1 = 8'h4C;

    localparam int VER_OFF  = 2;
    localparam int TYPE_OFF = 3;
    localparam int SRC_OFF  = 4;
    localparam int DST_OFF  = 12;
    localparam int SVC_OFF  = 20;
    localparam int SEQ_OFF  = 24;
    localparam int PLEN_OFF = 28;
    localparam int CRC_OFF  = 32;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_SHORT = 3'd1;
    localparam logic [2:0] ST_MAGIC = 3'd2;
    localparam logic [2:0] ST_SIZE  = 3'd3;
    localparam logic [2:0] ST_CRC   = 3'd4;

    localparam logic REG_VERSION     = 1'b0;
    localparam logic REG_MAX_PAYLOAD = 1'b1;

    typedef struct packed {
        logic [7:0]       data;
        logic             last;
        logic             hdr_wr;
        logic [IDX_W-1:0] hdr_idx;
        logic [CNT_W-1:0] count;
    } lfd_entry_t;

    typedef struct packed {
        logic [7:0]  protocol_version;
        logic [15:0] max_payload;
    } lfd_cfg_t;

endpackage

@@ sv/link_frame_decoder.sv @@
// Link frame decoder: takes a frame one byte per cycle while s_ready is high, s_frame_end
// on its last byte, and gives one result per frame: a status and the fields of its 36-byte
// little-endian header. The payload after the header is folded into a reflected CRC-32
// and is not passed out. The result for a frame goes through the two-entry byte queue
// and the evaluation stage ahead of the output register. Bytes keep flowing while a
// result waits; the back part holds only when a new frame has ended and the previous
// result is still not taken. Registers on the APB port: protocol_version at 0x0,
// max_payload at 0x4.
// Depends on lfd_pkg, lfd_front, lfd_fifo and lfd_back.
module link_frame_decoder import lfd_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_data_byte,
    input  logic               s_frame_end,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_status,
    output logic [7:0]         m_frame_type,
    output logic [63:0]        m_source_node,
    output logic [63:0]        m_target_node,
    output logic [31:0]        m_service_code,
    output logic [31:0]        m_sequence_number,
    output logic [15:0]        m_payload_length
);

    lfd_cfg_t   cfg_reg, cfg_next;
    logic       cfg_wr;
    logic       push_valid, q_full, pop, pop_valid;
    lfd_entry_t push_entry, pop_entry;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr) begin
            case (paddr[2])
                REG_VERSION:     cfg_next.protocol_version = pwdata[7:0];
                REG_MAX_PAYLOAD: cfg_next.max_payload      = pwdata[15:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_VERSION:     prdata = {24'd0, cfg_reg.protocol_version};
            REG_MAX_PAYLOAD: prdata = {16'd0, cfg_reg.max_payload};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.protocol_version <= 8'd1;
            cfg_reg.max_payload      <= 16'd1024;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    lfd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_data_byte (s_data_byte),
        .s_frame_end (s_frame_end),
        .s_ready     (s_ready),
        .q_full      (q_full),
        .push_valid  (push_valid),
        .push_entry  (push_entry)
    );

    lfd_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_entry  (pop_entry)
    );

    lfd_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg               (cfg_reg),
        .pop_valid         (pop_valid),
        .pop_entry         (pop_entry),
        .pop               (pop),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_frame_type      (m_frame_type),
        .m_source_node     (m_source_node),
        .m_target_node     (m_target_node),
        .m_service_code    (m_service_code),
        .m_sequence_number (m_sequence_number),
        .m_payload_length  (m_payload_length)
    );

endmodule

@@ sv/lfd_fifo.sv @@
// Short queue of classified bytes between the front and back parts.
// Depends on lfd_pkg.
module lfd_fifo import lfd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push_valid,
    input  lfd_entry_t push_entry,
    output logic       full,
    input  logic       pop,
    output logic       pop_valid,
    output lfd_entry_t pop_entry
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(QUEUE_DEPTH);

    lfd_entry_t        slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              do_push, do_pop;

    assign full      = (fill_reg == FILL_FULL);
    assign pop_valid = (fill_reg != '0);
    assign pop_entry = slot_reg[rd_ptr_reg];
    assign do_push   = push_valid && !full;
    assign do_pop    = pop && pop_valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

@@ sv/lfd_front.sv @@
// Front part: accepts frame bytes, counts them and tags header or payload.
// Depends on lfd_pkg.
module lfd_front import lfd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic [7:0] s_data_byte,
    input  logic       s_frame_end,
    output logic       s_ready,
    input  logic       q_full,
    output logic       push_valid,
    output lfd_entry_t push_entry
);

    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] count_sat;
    logic             accept;

    assign s_ready    = !q_full;
    assign accept     = s_valid && s_ready;
    assign push_valid = accept;
    assign count_sat  = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;

    always_comb begin
        push_entry.data    = s_data_byte;
        push_entry.last    = s_frame_end;
        push_entry.hdr_wr  = (count_reg < CNT_W'(HEADER_BYTES));
        push_entry.hdr_idx = count_reg[IDX_W-1:0];
        push_entry.count   = count_sat;
    end

    always_comb begin
        count_next = count_reg;
        if (accept) begin
            count_next = s_frame_end ? '0 : count_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

endmodule

@@ sv/lfd_back.sv @@
// Back part: header capture, payload CRC-32, frame checks and result register.
// Depends on lfd_pkg.
module lfd_back import lfd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  lfd_cfg_t    cfg,
    input  logic        pop_valid,
    input  lfd_entry_t  pop_entry,
    output logic        pop,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [7:0]  m_frame_type,
    output logic [63:0] m_source_node,
    output logic [63:0] m_target_node,
    output logic [31:0] m_service_code,
    output logic [31:0] m_sequence_number,
    output logic [15:0] m_payload_length
);

    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    logic [7:0]       hdr_reg [HEADER_BYTES];
    logic [31:0]      crc_reg, crc_next;
    logic [31:0]      crc_done_reg;
    logic [CNT_W-1:0] count_done_reg;
    logic             pending_reg, pending_next;
    logic             m_valid_reg, m_valid_next;
    logic [2:0]       status_reg;
    logic [7:0]       type_reg;
    logic [63:0]      src_reg, dst_reg;
    logic [31:0]      svc_reg, seq_reg;
    logic [15:0]      plen_reg;

    logic             out_free, fire;
    logic [31:0]      crc_cur;
    logic [15:0]      plen;
    logic [31:0]      crc_hdr;
    logic [CNT_W-1:0] total;
    logic [2:0]       status;
    logic [63:0]      src, dst;
    logic [31:0]      svc, seq;

    assign out_free = !m_valid_reg || m_ready;
    assign fire     = pending_reg && out_free;
    assign pop      = pop_valid && (!pending_reg || out_free);
    assign crc_cur  = pop_entry.hdr_wr ? crc_reg : crc_byte(crc_reg, pop_entry.data);

    always_comb begin
        crc_next     = crc_reg;
        pending_next = fire ? 1'b0 : pending_reg;
        if (pop) begin
            crc_next = pop_entry.last ? CRC_INIT : crc_cur;
            if (pop_entry.last) begin
                pending_next = 1'b1;
            end
        end
        m_valid_next = fire ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_comb begin
        plen    = {hdr_reg[PLEN_OFF + 1], hdr_reg[PLEN_OFF]};
        crc_hdr = {hdr_reg[CRC_OFF + 3], hdr_reg[CRC_OFF + 2],
                   hdr_reg[CRC_OFF + 1], hdr_reg[CRC_OFF]};
        total   = CNT_W'(HEADER_BYTES) + {{(CNT_W - 16){1'b0}}, plen};
        for (int k = 0; k < 8; k++) begin
            src[8*k +: 8] = hdr_reg[SRC_OFF + k];
            dst[8*k +: 8] = hdr_reg[DST_OFF + k];
        end
        for (int k = 0; k < 4; k++) begin
            svc[8*k +: 8] = hdr_reg[SVC_OFF + k];
            seq[8*k +: 8] = hdr_reg[SEQ_OFF + k];
        end
        if (count_done_reg < CNT_W'(HEADER_BYTES)) begin
            status = ST_SHORT;
        end else if (hdr_reg[0] != MAGIC_0 || hdr_reg[1] != MAGIC_1
                     || hdr_reg[VER_OFF] != cfg.protocol_version) begin
            status = ST_MAGIC;
        end else if (plen > cfg.max_payload || count_done_reg != total) begin
            status = ST_SIZE;
        end else if (~crc_done_reg != crc_hdr) begin
            status = ST_CRC;
        end else begin
            status = ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg     <= CRC_INIT;
            pending_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            crc_reg     <= crc_next;
            pending_reg <= pending_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && pop_entry.hdr_wr) begin
            hdr_reg[pop_entry.hdr_idx] <= pop_entry.data;
        end
        if (pop && pop_entry.last) begin
            crc_done_reg   <= crc_cur;
            count_done_reg <= pop_entry.count;
        end
        if (fire) begin
            status_reg <= status;
            if (status == ST_OK) begin
                type_reg <= hdr_reg[TYPE_OFF];
                src_reg  <= src;
                dst_reg  <= dst;
                svc_reg  <= svc;
                seq_reg  <= seq;
                plen_reg <= plen;
            end else begin
                type_reg <= '0;
                src_reg  <= '0;
                dst_reg  <= '0;
                svc_reg  <= '0;
                seq_reg  <= '0;
                plen_reg <= '0;
            end
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = status_reg;
    assign m_frame_type      = type_reg;
    assign m_source_node     = src_reg;
    assign m_target_node     = dst_reg;
    assign m_service_code    = svc_reg;
    assign m_sequence_number = seq_reg;
    assign m_payload_length  = plen_reg;

endmodule

@@ sv/lfd_checker.sv @@
// Port-level checker for the link frame decoder, bound to the top level.
// Depends on lfd_pkg and link_frame_decoder_assert.svh.
`include "link_frame_decoder_assert.svh"

module lfd_checker import lfd_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_status,
    input logic [7:0]  m_frame_type,
    input logic [63:0] m_source_node,
    input logic [63:0] m_target_node,
    input logic [31:0] m_service_code,
    input logic [31:0] m_sequence_number,
    input logic [15:0] m_payload_length
);

    logic [218:0] result_bus;
    logic         fields_zero;
    logic         status_known;

    assign result_bus   = {m_status, m_frame_type, m_source_node, m_target_node,
                           m_service_code, m_sequence_number, m_payload_length};
    assign fields_zero  = ({m_frame_type, m_source_node, m_target_node, m_service_code,
                            m_sequence_number, m_payload_length} == '0);
    assign status_known = (m_status == ST_OK) || (m_status == ST_SHORT)
                          || (m_status == ST_MAGIC) || (m_status == ST_SIZE)
                          || (m_status == ST_CRC);

    `LFD_ASSERT_NEXT(a_result_held, m_valid && !m_ready, m_valid && $stable(result_bus))

    `LFD_ASSERT_IMPLY(a_error_fields_zero, m_valid && m_status != ST_OK, fields_zero)

    `LFD_ASSERT_IMPLY(a_ready_falls_on_transaction, $fell(s_ready), $past(s_valid))

    `LFD_ASSERT_IMPLY(a_status_code_known, m_valid, status_known)

endmodule

bind link_frame_decoder lfd_checker u_lfd_checker (.*);
